// ===== src/allpass_pole_for_phase_delay_unit_macros.svh =====
// assertion macros shared by the checker of the all-pass pole unit
// expects clk and rst_n in the scope of use
`ifndef ALLPASS_POLE_FOR_PHASE_DELAY_UNIT_MACROS_SVH
`define ALLPASS_POLE_FOR_PHASE_DELAY_UNIT_MACROS_SVH

// same-cycle implication
`define APD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define APD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/apd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// types, constants and helper functions of the all-pass pole unit
// no dependencies
package apd_pkg;

    localparam int CORDIC_STAGES  = 16;
    localparam int POLE_FRAC_BITS = 16;

    localparam int IN_W    = 16;
    localparam int BOUND_W = 17;
    localparam int ANG_W   = 32;
    localparam int REM_W   = 30;
    localparam int SIN_W   = 32;
    localparam int Z_W     = 33;
    localparam int POLE_W  = 24;
    localparam int CODE_W  = 3;

    localparam int QUOT_BITS = POLE_W + 1;
    localparam int MAG_W     = SIN_W;
    localparam int N_W       = MAG_W + POLE_FRAC_BITS + 2;
    localparam int D_W       = MAG_W + 1;
    localparam int R_W       = (N_W > D_W + QUOT_BITS) ? N_W : D_W + QUOT_BITS;
    localparam int CMP_W     = (POLE_W + 16 > BOUND_W + POLE_FRAC_BITS) ?
                               POLE_W + 16 : BOUND_W + POLE_FRAC_BITS;

    localparam int CORDIC_LAT = CORDIC_STAGES + 2;
    localparam int DIV_LAT    = QUOT_BITS + 4;

    localparam logic [31:0] PI_Q30_X2 = 32'hC90FDAA2;
    localparam logic signed [SIN_W-1:0] X_INIT = SIN_W'(32'sd536870912);

    // angle scaling: a*2^32/92160 = a*46603 + (17a+22)/45 and the half-angle twin
    localparam logic [15:0] HF_MUL    = 16'd46603;
    localparam logic [15:0] HH_MUL    = 16'd23301;
    localparam logic [4:0]  RND_OFS   = 5'd22;
    localparam logic [21:0] RECIP_45  = 22'd2982617;
    localparam int          RECIP_SH  = 27;

    localparam logic [BOUND_W-1:0] POLE_MIN_RST = BOUND_W'(6554);
    localparam logic [BOUND_W-1:0] POLE_MAX_RST = BOUND_W'(62259);

    localparam logic [0:0] CFG_POLE_MIN = 1'd0;
    localparam logic [0:0] CFG_POLE_MAX = 1'd1;

    localparam logic [CODE_W-1:0] CODE_NONE       = 3'd0;
    localparam logic [CODE_W-1:0] CODE_SINGLE     = 3'd1;
    localparam logic [CODE_W-1:0] CODE_DOUBLE     = 3'd2;
    localparam logic [CODE_W-1:0] CODE_INV_SINGLE = 3'd3;
    localparam logic [CODE_W-1:0] CODE_INV_DOUBLE = 3'd4;

    typedef logic [ANG_W-1:0]         ang_t;
    typedef logic signed [SIN_W-1:0]  sin_t;
    typedef logic signed [POLE_W-1:0] pole_t;
    typedef logic [1:0]               quad_t;

    // arctangent of 2^-i in q30 radians, rounded
    function automatic logic signed [Z_W-1:0] atan_q30(input int i);
        logic [31:0] v;
        case (i)
            0:       v = 32'd843314857;
            1:       v = 32'd497837829;
            2:       v = 32'd263043837;
            3:       v = 32'd133525159;
            4:       v = 32'd67021687;
            5:       v = 32'd33543516;
            6:       v = 32'd16775851;
            7:       v = 32'd8388437;
            8:       v = 32'd4194283;
            9:       v = 32'd2097149;
            31:      v = 32'd1;
            default: v = 32'd1 << (30 - i);
        endcase
        return Z_W'(v);
    endfunction

    // sine from quadrant and cordic outputs
    function automatic sin_t sin_sel(input quad_t q, input sin_t x, input sin_t y);
        sin_t r;
        case (q)
            2'd0:    r = y;
            2'd1:    r = x;
            2'd2:    r = -y;
            default: r = -x;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/apd_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// pipelined rotation cordic: binary angle in, unscaled cos/sin of the remainder out
// depends on apd_pkg
module apd_cordic (
    input  wire logic          clk,
    input  wire logic          en,
    input  apd_pkg::ang_t      angle,
    output apd_pkg::sin_t      x,
    output apd_pkg::sin_t      y,
    output apd_pkg::quad_t     quad
);
    import apd_pkg::*;

    logic [REM_W+31:0] prod_reg;
    quad_t             qin_reg;
    sin_t              x_reg [0:CORDIC_STAGES];
    sin_t              y_reg [0:CORDIC_STAGES];
    logic signed [Z_W-1:0] z_reg [0:CORDIC_STAGES];
    quad_t             q_reg [0:CORDIC_STAGES];
    logic [REM_W+31:0] z_rnd_next;

    // remainder to q30 radians
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= (REM_W+32)'(angle[REM_W-1:0]) * (REM_W+32)'(PI_Q30_X2);
            qin_reg  <= angle[ANG_W-1 -: 2];
        end
    end

    assign z_rnd_next = prod_reg + ((REM_W+32)'(1) << 30);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg[0] <= Z_W'(z_rnd_next >> 31);
            x_reg[0] <= X_INIT;
            y_reg[0] <= '0;
            q_reg[0] <= qin_reg;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q30(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q30(i);
                end
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    assign x    = x_reg[CORDIC_STAGES];
    assign y    = y_reg[CORDIC_STAGES];
    assign quad = q_reg[CORDIC_STAGES];

endmodule
`default_nettype wire

// ===== src/apd_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// pipelined restoring divider: rounded, saturated pole = num / den
// depends on apd_pkg
module apd_div (
    input  wire logic      clk,
    input  wire logic      en,
    input  apd_pkg::sin_t  num,
    input  apd_pkg::sin_t  den,
    output apd_pkg::pole_t pole
);
    import apd_pkg::*;

    typedef struct packed {
        logic neg;
        logic nneg;
        logic dz;
        logic sat;
    } div_flags_t;

    localparam logic [QUOT_BITS-1:0] Q_HI = QUOT_BITS'((1 << (POLE_W - 1)) - 1);
    localparam logic [QUOT_BITS-1:0] Q_LO = QUOT_BITS'(1 << (POLE_W - 1));

    logic [MAG_W-1:0] un_reg, ud_reg;
    div_flags_t       f1_reg, f2_reg;
    logic [N_W-1:0]   n_reg;
    logic [D_W-1:0]   d2_reg;
    logic [R_W-1:0]   r_reg [0:QUOT_BITS];
    logic [D_W-1:0]   d_reg [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] q_reg [0:QUOT_BITS];
    div_flags_t       f_reg [0:QUOT_BITS];
    pole_t            pole_reg;
    pole_t            pole_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            un_reg      <= num[SIN_W-1] ? MAG_W'(-num) : MAG_W'(num);
            ud_reg      <= den[SIN_W-1] ? MAG_W'(-den) : MAG_W'(den);
            f1_reg.neg  <= num[SIN_W-1] ^ den[SIN_W-1];
            f1_reg.nneg <= num[SIN_W-1];
            f1_reg.dz   <= (den == '0);
            f1_reg.sat  <= 1'b0;
            n_reg       <= (N_W'(un_reg) << (POLE_FRAC_BITS + 1)) + N_W'(ud_reg);
            d2_reg      <= {ud_reg, 1'b0};
            f2_reg      <= f1_reg;
            r_reg[0]    <= R_W'(n_reg);
            d_reg[0]    <= d2_reg;
            q_reg[0]    <= '0;
            f_reg[0]    <= '{neg: f2_reg.neg, nneg: f2_reg.nneg, dz: f2_reg.dz,
                             sat: (R_W'(n_reg) >= (R_W'(d2_reg) << QUOT_BITS))};
        end
    end

    // one quotient bit per stage, msb first
    for (genvar j = 0; j < QUOT_BITS; j++)
    begin : g_bit
        logic [R_W:0] trial;
        assign trial = {1'b0, r_reg[j]} - {1'b0, R_W'(d_reg[j]) << (QUOT_BITS - 1 - j)};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[j+1] <= trial[R_W] ? r_reg[j] : trial[R_W-1:0];
                q_reg[j+1] <= q_reg[j] | (QUOT_BITS'(!trial[R_W]) << (QUOT_BITS - 1 - j));
                d_reg[j+1] <= d_reg[j];
                f_reg[j+1] <= f_reg[j];
            end
        end
    end

    always_comb
    begin
        if (f_reg[QUOT_BITS].dz)
            pole_next = f_reg[QUOT_BITS].nneg ? pole_t'(Q_LO) : pole_t'(Q_HI);
        else if (f_reg[QUOT_BITS].neg)
            pole_next = (f_reg[QUOT_BITS].sat || q_reg[QUOT_BITS] > Q_LO) ?
                        pole_t'(Q_LO) : -pole_t'(q_reg[QUOT_BITS]);
        else
            pole_next = (f_reg[QUOT_BITS].sat || q_reg[QUOT_BITS] > Q_HI) ?
                        pole_t'(Q_HI) : pole_t'(q_reg[QUOT_BITS]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            pole_reg <= pole_next;
    end

    assign pole = pole_reg;

endmodule
`default_nettype wire

// ===== src/allpass_pole_for_phase_delay_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// top level of the all-pass pole unit: angle scaling, four cordics, four dividers, pick
// depends on apd_pkg, apd_cordic, apd_div
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    s_tdata: angle_deg, norm_freq
// m_*       out  m_tvalid/m_tready    m_tdata: pole, result_code
// cfg_*     in   cfg_we               cfg_index, cfg_wdata (pole_min, pole_max)
//
// one beat per cycle sustained while results at m_* are taken; the pipeline depth is set
// by the cordic chain and the bit-per-stage divider
// the whole pipeline moves together: it holds while a result waits at m_* and is not taken
// valid bits ride alongside the data; reset clears them and presets the bound registers only
module allpass_pole_for_phase_delay_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [31:0]                  s_tdata,   // angle_deg[15:0], norm_freq[31:16]
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [31:0]                       m_tdata,   // pole[23:0], result_code[26:24], zero
    input  wire logic                         cfg_we,
    input  wire logic [0:0]                   cfg_index,
    input  wire logic [apd_pkg::BOUND_W-1:0]  cfg_wdata
);
    import apd_pkg::*;

    localparam int VLAT = 3 + CORDIC_LAT + 1 + DIV_LAT + 1;

    logic                 adv;
    logic [VLAT-1:0]      vld_reg;
    logic [BOUND_W-1:0]   pole_min_reg, pole_max_reg;

    // stage 1: products of the angle scaling
    logic [31:0]          pa_reg, pb_reg;
    logic [42:0]          va_reg, vb_reg;
    logic [IN_W-1:0]      nf1_reg;
    logic [20:0]          va_in, vb_in;
    // stage 2: half phase terms and frequency terms
    ang_t                 hf_reg, hh_reg, base_reg, bw_reg;
    // stage 3: the four cordic angles
    ang_t                 phf_reg, psf_reg, phh_reg, psh_reg;
    // cordic outputs
    sin_t                 xa [0:3];
    sin_t                 ya [0:3];
    quad_t                qa [0:3];
    // candidate numerators and denominators
    sin_t                 num_reg [0:3];
    sin_t                 den_reg [0:3];
    pole_t                pole_c [0:3];
    logic [3:0]           fit;
    pole_t                pole_next;
    logic [CODE_W-1:0]    code_next;
    logic [POLE_W-1:0]    pole_out_reg;
    logic [CODE_W-1:0]    code_out_reg;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[VLAT-1];
    assign m_tdata  = {{(32 - POLE_W - CODE_W){1'b0}}, code_out_reg, pole_out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[VLAT-2:0], s_tvalid};
    end

    // bound registers, to be written only while idle; the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_min_reg <= POLE_MIN_RST;
            pole_max_reg <= POLE_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLE_MIN: pole_min_reg <= cfg_wdata;
                CFG_POLE_MAX: pole_max_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // 17a + 22 and 31a + 22, then divided by 45 through a reciprocal
    assign va_in = (21'(s_tdata[15:0]) << 4) + 21'(s_tdata[15:0]) + 21'(RND_OFS);
    assign vb_in = (21'(s_tdata[15:0]) << 5) - 21'(s_tdata[15:0]) + 21'(RND_OFS);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg   <= 32'(s_tdata[15:0]) * 32'(HF_MUL);
            pb_reg   <= 32'(s_tdata[15:0]) * 32'(HH_MUL);
            va_reg   <= 43'(va_in) * 43'(RECIP_45);
            vb_reg   <= 43'(vb_in) * 43'(RECIP_45);
            nf1_reg  <= s_tdata[31:16];
            // phase terms wrap modulo one turn
            hf_reg   <= pa_reg + ANG_W'(va_reg >> RECIP_SH);
            hh_reg   <= pb_reg + ANG_W'(vb_reg >> RECIP_SH);
            base_reg <= ANG_W'(nf1_reg) << 15;
            bw_reg   <= (ANG_W'(nf1_reg) << 15) - (ANG_W'(nf1_reg) << 16);
            phf_reg  <= base_reg - hf_reg;
            psf_reg  <= bw_reg - hf_reg;
            phh_reg  <= base_reg - hh_reg;
            psh_reg  <= bw_reg - hh_reg;
        end
    end

    // index 0: phi full, 1: psi full, 2: phi half, 3: psi half
    apd_cordic u_cordic_phf (.clk(clk), .en(adv), .angle(phf_reg),
                             .x(xa[0]), .y(ya[0]), .quad(qa[0]));
    apd_cordic u_cordic_psf (.clk(clk), .en(adv), .angle(psf_reg),
                             .x(xa[1]), .y(ya[1]), .quad(qa[1]));
    apd_cordic u_cordic_phh (.clk(clk), .en(adv), .angle(phh_reg),
                             .x(xa[2]), .y(ya[2]), .quad(qa[2]));
    apd_cordic u_cordic_psh (.clk(clk), .en(adv), .angle(psh_reg),
                             .x(xa[3]), .y(ya[3]), .quad(qa[3]));

    // adding a quarter turn to phi and psi only moves the quadrant on
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg[0] <= sin_sel(qa[0], xa[0], ya[0]);
            den_reg[0] <= sin_sel(qa[1], xa[1], ya[1]);
            num_reg[1] <= sin_sel(qa[2], xa[2], ya[2]);
            den_reg[1] <= sin_sel(qa[3], xa[3], ya[3]);
            num_reg[2] <= sin_sel(2'(qa[0] + 2'd1), xa[0], ya[0]);
            den_reg[2] <= sin_sel(2'(qa[1] + 2'd1), xa[1], ya[1]);
            num_reg[3] <= sin_sel(2'(qa[2] + 2'd1), xa[2], ya[2]);
            den_reg[3] <= sin_sel(2'(qa[3] + 2'd1), xa[3], ya[3]);
        end
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_div
        logic [POLE_W-1:0] mag;
        logic [CMP_W-1:0]  mag_cmp;
        apd_div u_div (.clk(clk), .en(adv), .num(num_reg[k]), .den(den_reg[k]),
                       .pole(pole_c[k]));
        assign mag     = pole_c[k][POLE_W-1] ? POLE_W'(-pole_c[k]) : POLE_W'(pole_c[k]);
        assign mag_cmp = CMP_W'(mag) << 16;
        // bounds are exclusive on both sides
        assign fit[k]  = (mag_cmp > (CMP_W'(pole_min_reg) << POLE_FRAC_BITS)) &&
                         (mag_cmp < (CMP_W'(pole_max_reg) << POLE_FRAC_BITS));
    end

    // first fitting candidate wins, otherwise the sign-inverted double is shown
    always_comb
    begin
        pole_next = pole_c[3];
        code_next = CODE_NONE;
        if (fit[0])
        begin
            pole_next = pole_c[0];
            code_next = CODE_SINGLE;
        end
        else if (fit[1])
        begin
            pole_next = pole_c[1];
            code_next = CODE_DOUBLE;
        end
        else if (fit[2])
        begin
            pole_next = pole_c[2];
            code_next = CODE_INV_SINGLE;
        end
        else if (fit[3])
        begin
            code_next = CODE_INV_DOUBLE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pole_out_reg <= pole_next;
            code_out_reg <= code_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/apd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// port-level checks of the all-pass pole unit, bound to the top level
// depends on apd_pkg and allpass_pole_for_phase_delay_unit_macros.svh
`include "allpass_pole_for_phase_delay_unit_macros.svh"
module apd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);
    import apd_pkg::*;

    // held result beat stays put
    `APD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")
    // an empty output stage never blocks the input
    `APD_ASSERT_NOW(a_ready, !m_tvalid, s_tready, "input blocked with empty output")
    // result code only takes its five meanings
    `APD_ASSERT_NOW(a_code, m_tvalid, m_tdata[26:24] <= CODE_INV_DOUBLE, "result code out of range")
    // padding bits stay zero
    `APD_ASSERT_NOW(a_pad, m_tvalid, m_tdata[31:27] == 5'd0, "padding bits set")
endmodule

bind allpass_pole_for_phase_delay_unit apd_checker u_apd_checker (.*);
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for the all-pass pole unit: bursty stream stimulus, stalling sink,
// bound register phases and a bit-exact pole predictor; depends on apd_pkg and the unit
module tb;
    import apd_pkg::*;

    typedef struct {
        pole_t             pole;
        logic [CODE_W-1:0] code;
        logic [15:0]       angle;
        logic [15:0]       freq;
    } pole_result_t;

    // keeps the bound copies, predicts each pole and holds the poles still to arrive
    class pole_scoreboard;
        longint unsigned lo_bound;
        longint unsigned hi_bound;
        longint          atan_lut [32];
        pole_result_t    due_q [$];
        int              errors;

        function new();
            longint unsigned acc;
            longint unsigned term;
            int              e;
            lo_bound = 6554;
            hi_bound = 62259;
            errors   = 0;
            atan_lut[0] = 843314857;
            for (int i = 1; i < 32; i++)
            begin
                acc = 0;
                for (int k = 0; ; k++)
                begin
                    e = i * (2 * k + 1);
                    if (e > 62)
                        break;
                    term = (64'd1 << (62 - e)) / longint'(2 * k + 1);
                    if ((k & 1) == 0)
                        acc += term;
                    else
                        acc -= term;
                end
                atan_lut[i] = longint'((acc + (64'd1 << 31)) >> 32);
            end
        endfunction

        function void set_bound(logic [0:0] idx, logic [BOUND_W-1:0] val);
            if (idx == CFG_POLE_MIN)
                lo_bound = val;
            else
                lo_bound = lo_bound;
            if (idx == CFG_POLE_MAX)
                hi_bound = val;
        endfunction

        // rotation cordic on a binary angle, quadrant folded afterwards
        function longint sine(logic [31:0] ang);
            longint unsigned rem;
            longint          z, x, y, dx, dy;
            rem = ang[29:0];
            z   = longint'((rem * 64'hC90FDAA2 + (64'd1 << 30)) >> 31);
            x   = 64'sd1 << 29;
            y   = 0;
            for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= atan_lut[i];
                end
                else
                begin
                    x += dx; y -= dy; z += atan_lut[i];
                end
            end
            case (ang[31:30])
                2'd0:    return y;
                2'd1:    return x;
                2'd2:    return -y;
                default: return -x;
            endcase
        endfunction

        // rounded and saturated division, zero divisor saturates by the sign of the dividend
        function longint divide(longint n, longint d);
            longint unsigned un, ud, q;
            if (d == 0)
                return (n < 0) ? -64'sd8388608 : 64'sd8388607;
            un = (n < 0) ? -n : n;
            ud = (d < 0) ? -d : d;
            q  = ((un << (POLE_FRAC_BITS + 1)) + ud) / (2 * ud);
            if ((n < 0) != (d < 0))
            begin
                if (q > 8388608)
                    q = 8388608;
                return -longint'(q);
            end
            if (q > 8388607)
                q = 8388607;
            return longint'(q);
        endfunction

        function void note(logic [31:0] beat);
            logic [CODE_W-1:0] code_of [4];
            longint unsigned   a, f, mag;
            logic [31:0]       hf, hh, base, w, phi, psi;
            longint            p;
            pole_result_t      r;
            code_of = '{CODE_SINGLE, CODE_DOUBLE, CODE_INV_SINGLE, CODE_INV_DOUBLE};
            a    = beat[15:0];
            f    = beat[31:16];
            hf   = 32'(((a << 32) + 46080) / 92160);
            hh   = 32'(((a << 32) + 92160) / 184320);
            base = 32'(f << 15);
            w    = 32'(f << 16);
            r.code  = CODE_NONE;
            r.angle = beat[15:0];
            r.freq  = beat[31:16];
            p = 0;
            for (int k = 0; k < 4; k++)
            begin
                phi = base - (((k & 1) != 0) ? hh : hf);
                if (k >= 2)
                    phi += 32'h40000000;
                psi = phi - w;
                p   = divide(sine(phi), sine(psi));
                mag = (p < 0) ? -p : p;
                if (mag > lo_bound && mag < hi_bound)
                begin
                    r.code = code_of[k];
                    break;
                end
            end
            r.pole = pole_t'(p);
            due_q.push_back(r);
        endfunction

        function void check(logic [31:0] beat);
            pole_result_t r;
            if (due_q.size() == 0)
            begin
                $display("%0t: unexpected pole beat %h", $time, beat);
                errors++;
                return;
            end
            r = due_q.pop_front();
            if (beat[23:0] !== r.pole)
            begin
                $display("%0t: pole for angle %0d freq %0d expected %0d got %0d", $time,
                         r.angle, r.freq, r.pole, $signed(beat[23:0]));
                errors++;
            end
            if (beat[26:24] !== r.code)
            begin
                $display("%0t: code for angle %0d freq %0d expected %0d got %0d", $time,
                         r.angle, r.freq, r.code, beat[26:24]);
                errors++;
            end
        endfunction
    endclass

    localparam int LATENCY    = 3 + CORDIC_LAT + 1 + DIV_LAT + 1;
    localparam int IDLE_LIMIT = 4000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata = '0;      // angle_deg[15:0], norm_freq[31:16]
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [31:0]         m_tdata;           // pole[23:0], result_code[26:24], zero
    logic                cfg_we = 1'b0;
    logic [0:0]          cfg_index = CFG_POLE_MIN;
    logic [BOUND_W-1:0]  cfg_wdata = '0;

    pole_scoreboard sb = new();
    int             in_beats   = 0;
    int             idle_count = 0;
    int             burst_left = 0;

    allpass_pole_for_phase_delay_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // both handshakes are observed here, on the values that held before the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                sb.note(s_tdata);
                in_beats++;
            end
            if (m_tvalid && m_tready)
                sb.check(m_tdata);
            // watchdog: only counts while something is outstanding
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (!s_tvalid && sb.due_q.size() == 0))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // sink: stall mode changes every so often, one long hold-off once the pipe has traffic
    int  sink_mode  = 0;
    int  sink_timer = 0;
    int  hold_left  = 0;
    bit  hold_done  = 0;
    always @(posedge clk)
    begin
        if (!hold_done && in_beats > 300)
        begin
            hold_done = 1;
            hold_left = 400;
        end
        if (sink_timer == 0)
        begin
            sink_mode  = $urandom_range(0, 3);
            sink_timer = $urandom_range(16, 96);
        end
        sink_timer--;
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            case (sink_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 1);
                2:       m_tready <= ($urandom_range(0, 7) == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
    end

    // one beat, with a random gap before it when a burst has run out
    task automatic send_beat(logic [15:0] angle, logic [15:0] freq);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {freq, angle};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_random();
        if ($urandom_range(0, 6) == 0)
            send_beat(16'($urandom), 16'($urandom));
        else
            send_beat(16'($urandom_range(0, 46080)), 16'($urandom_range(0, 32768)));
    endtask

    // stop offering, let every pole come back, then let the pipe run dry
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.due_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_bound(logic [0:0] idx, logic [BOUND_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.set_bound(idx, val);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(logic [BOUND_W-1:0] lo, logic [BOUND_W-1:0] hi, int n);
        write_bound(CFG_POLE_MIN, lo);
        write_bound(CFG_POLE_MAX, hi);
        repeat (n) send_random();
        drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset bounds: range corners, half turn, zero denominator at zero angle and frequency
        send_beat(16'd0, 16'd0);
        send_beat(16'd46080, 16'd0);
        send_beat(16'd0, 16'd32768);
        send_beat(16'd46080, 16'd32768);
        send_beat(16'd23040, 16'd16384);
        send_beat(16'd11520, 16'd8192);
        send_beat(16'd34560, 16'd24576);
        send_beat(16'd65535, 16'd65535);
        send_beat(16'd65535, 16'd0);
        send_beat(16'd0, 16'd65535);
        send_beat(16'd1, 16'd1);
        send_beat(16'd128, 16'd655);
        send_beat(16'd5760, 16'd4096);
        send_beat(16'd40000, 16'd30000);
        send_beat(16'h5555, 16'hAAAA);
        send_beat(16'hAAAA, 16'h5555);
        send_beat(16'd23040, 16'd0);
        send_beat(16'd23040, 16'd32768);
        repeat (200) send_random();
        drain();

        run_phase(17'd0, 17'd65536, 150);       // widest sensible window
        run_phase(17'd65536, 17'd65536, 80);    // nothing fits, fourth candidate returned
        run_phase(17'd0, 17'h1FFFF, 100);       // any non-zero pole of magnitude below 0x1FFFF fits
        run_phase(17'd32768, 17'd98304, 120);
        run_phase(17'd6554, 17'd62259, 0);      // back to reset values, idle write
        run_phase(17'($urandom_range(0, 40000)), 17'($urandom_range(40000, 131071)), 130);

        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
